/* rtl/es2cal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// es2cal_pkg: constants for the epoch seconds to calendar converter
// Zone offset, divisor constants with their scaled reciprocals, year layout
// of the four-year cycle and the month start table.
// ----------------------------------------------------------------------------
package es2cal_pkg;

  // field widths
  localparam int unsigned EpochW  = 31;
  localparam int unsigned YearW   = 11;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // fixed zone offset, eight hours
  localparam logic [31:0] ZONE_OFFSET = 32'd28800;

  // seconds per day = 128 * 675; divide by 675 with a 2^32 reciprocal
  localparam logic [9:0]  DAY_ODD     = 10'd675;
  localparam logic [22:0] DAY_RECIP   = 23'd6362914;

  // days per four-year cycle, 2^26 reciprocal
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam logic [15:0] CYCLE_RECIP = 16'd45933;

  // seconds per hour, 2^29 reciprocal
  localparam logic [11:0] HOUR_SECS   = 12'd3600;
  localparam logic [17:0] HOUR_RECIP  = 18'd149130;

  // seconds per minute, 2^18 reciprocal
  localparam logic [5:0]  MIN_SECS    = 6'd60;
  localparam logic [12:0] MIN_RECIP   = 13'd4369;

  // year starts within the cycle; the third year is the leap year
  localparam logic [10:0] YEAR1_START = 11'd365;
  localparam logic [10:0] YEAR2_START = 11'd730;
  localparam logic [10:0] YEAR3_START = 11'd1096;
  localparam logic [10:0] BASE_YEAR   = 11'd1970;

  // first day of each month in a common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // month start with the leap day added after february
  function automatic logic [8:0] month_start(logic [3:0] idx, logic leap);
    logic [8:0] base;
    base = MONTH_START[idx];
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* rtl/epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: unix seconds to local calendar date and time
// Ten-stage pipeline: zone offset, day split, cycle/year/month split and
// hour/minute/second split, each division done by reciprocal multiply with
// a one-step correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel valid_i / epoch_seconds_i / stall_o carries one word of
//   seconds since 1970-01-01 00:00:00 UTC. Output channel valid_o / year_o /
//   month_o / day_o / hour_o / minute_o / second_o / stall_i carries the
//   date and time at UTC plus eight hours.
//   One word can be taken every cycle unless a result waits on a stalled
//   receiver; throughput is then one word per cycle through the ten
//   register stages.
//   Reset clears all stage valid bits; the pipeline comes up empty.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and stall_o rises in the same cycle, so no word is dropped or
//   repeated; it moves again the cycle stall_i falls.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
  import es2cal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [EpochW-1:0]  epoch_seconds_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o,
  output logic [HourW-1:0]   hour_o,
  output logic [MinuteW-1:0] minute_o,
  output logic [SecondW-1:0] second_o
);

  localparam int unsigned Stages = 10;

  logic              en;
  logic [Stages-1:0] vld_q;

  // stage registers
  logic [31:0] s1_secs_q;
  logic [24:0] s2_q1_q;
  logic [6:0]  s2_lo_q;
  logic [14:0] s2_dest_q;
  logic [14:0] s3_dest_q;
  logic [10:0] s3_draw_q;
  logic [6:0]  s3_lo_q;
  logic [14:0] s4_days_q;
  logic [16:0] s4_tod_q;
  logic [14:0] s5_days_q;
  logic [16:0] s5_tod_q;
  logic [4:0]  s5_cest_q;
  logic [4:0]  s5_hest_q;
  logic [4:0]  s6_cest_q;
  logic [11:0] s6_craw_q;
  logic [4:0]  s6_hest_q;
  logic [12:0] s6_hraw_q;
  logic [4:0]  s7_cyc_q;
  logic [10:0] s7_doy_q;
  logic [4:0]  s7_hour_q;
  logic [11:0] s7_rem_q;
  logic [10:0] s8_year_q;
  logic [8:0]  s8_doy_q;
  logic        s8_leap_q;
  logic [4:0]  s8_hour_q;
  logic [11:0] s8_rem_q;
  logic [5:0]  s8_mest_q;
  logic [10:0] s9_year_q;
  logic [3:0]  s9_month_q;
  logic [4:0]  s9_day_q;
  logic [4:0]  s9_hour_q;
  logic [5:0]  s9_mest_q;
  logic [6:0]  s9_sraw_q;
  logic [10:0] s10_year_q;
  logic [3:0]  s10_month_q;
  logic [4:0]  s10_day_q;
  logic [4:0]  s10_hour_q;
  logic [5:0]  s10_min_q;
  logic [5:0]  s10_sec_q;

  // next values
  logic [31:0] s1_secs_d;
  logic [47:0] day_prod;
  logic [24:0] day_back;
  logic [24:0] s3_draw_full;
  logic [14:0] s4_days_d;
  logic [9:0]  s4_r_d;
  logic [30:0] cyc_prod;
  logic [34:0] hr_prod;
  logic [15:0] cyc_back;
  logic [15:0] craw_full;
  logic [16:0] hr_back;
  logic [16:0] hraw_full;
  logic [4:0]  s7_cyc_d;
  logic [10:0] s7_doy_d;
  logic [4:0]  s7_hour_d;
  logic [11:0] s7_rem_d;
  logic [10:0] s8_doy_full;
  logic [1:0]  s8_yoff_d;
  logic        s8_leap_d;
  logic [10:0] s8_year_d;
  logic [24:0] min_prod;
  logic [3:0]  m_idx;
  logic [8:0]  m_base;
  logic [8:0]  day_full;
  logic [11:0] min_back;
  logic [11:0] sraw_full;
  logic [5:0]  s10_min_d;
  logic [5:0]  s10_sec_d;

  // global advance: hold everything while a result waits on a stalled receiver
  assign en      = !(vld_q[Stages-1] && stall_i);
  assign stall_o = !en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  // stage 1: add zone offset
  assign s1_secs_d = 32'(epoch_seconds_i) + ZONE_OFFSET;

  // stage 2: estimate days as (secs / 128) / 675
  assign day_prod = 48'(s1_secs_q[31:7]) * 48'(DAY_RECIP);

  // stage 3: remainder of the day estimate
  assign day_back     = 25'(s2_dest_q) * 25'(DAY_ODD);
  assign s3_draw_full = s2_q1_q - day_back;

  // stage 4: correct the day count, rebuild time of day
  always_comb begin
    if (s3_draw_q >= 11'(DAY_ODD)) begin
      s4_days_d = s3_dest_q + 15'd1;
      s4_r_d    = 10'(s3_draw_q - 11'(DAY_ODD));
    end else begin
      s4_days_d = s3_dest_q;
      s4_r_d    = s3_draw_q[9:0];
    end
  end

  // stage 5: estimate four-year cycles and hours
  assign cyc_prod = 31'(s4_days_q) * 31'(CYCLE_RECIP);
  assign hr_prod  = 35'(s4_tod_q) * 35'(HOUR_RECIP);

  // stage 6: remainders of both estimates
  assign cyc_back  = 16'(s5_cest_q) * 16'(CYCLE_DAYS);
  assign craw_full = 16'(s5_days_q) - cyc_back;
  assign hr_back   = 17'(s5_hest_q) * 17'(HOUR_SECS);
  assign hraw_full = s5_tod_q - hr_back;

  // stage 7: correct cycle and hour
  always_comb begin
    if (s6_craw_q >= 12'(CYCLE_DAYS)) begin
      s7_cyc_d = s6_cest_q + 5'd1;
      s7_doy_d = 11'(s6_craw_q - 12'(CYCLE_DAYS));
    end else begin
      s7_cyc_d = s6_cest_q;
      s7_doy_d = s6_craw_q[10:0];
    end
    if (s6_hraw_q >= 13'(HOUR_SECS)) begin
      s7_hour_d = s6_hest_q + 5'd1;
      s7_rem_d  = 12'(s6_hraw_q - 13'(HOUR_SECS));
    end else begin
      s7_hour_d = s6_hest_q;
      s7_rem_d  = s6_hraw_q[11:0];
    end
  end

  // stage 8: year within the cycle, minute estimate
  always_comb begin
    s8_leap_d = 1'b0;
    if (s7_doy_q >= YEAR3_START) begin
      s8_doy_full = s7_doy_q - YEAR3_START;
      s8_yoff_d   = 2'd3;
    end else if (s7_doy_q >= YEAR2_START) begin
      s8_doy_full = s7_doy_q - YEAR2_START;
      s8_yoff_d   = 2'd2;
      s8_leap_d   = 1'b1;
    end else if (s7_doy_q >= YEAR1_START) begin
      s8_doy_full = s7_doy_q - YEAR1_START;
      s8_yoff_d   = 2'd1;
    end else begin
      s8_doy_full = s7_doy_q;
      s8_yoff_d   = 2'd0;
    end
    s8_year_d = BASE_YEAR + 11'({s7_cyc_q, 2'b00}) + 11'(s8_yoff_d);
  end

  assign min_prod = 25'(s7_rem_q) * 25'(MIN_RECIP);

  // stage 9: month by parallel compares against month starts
  always_comb begin
    m_idx  = '0;
    m_base = '0;
    for (int k = 1; k < 12; k++) begin
      if (s8_doy_q >= month_start(4'(k), s8_leap_q)) begin
        m_idx  = 4'(k);
        m_base = month_start(4'(k), s8_leap_q);
      end
    end
    day_full = s8_doy_q - m_base + 9'd1;
  end

  assign min_back  = 12'(s8_mest_q) * 12'(MIN_SECS);
  assign sraw_full = s8_rem_q - min_back;

  // stage 10: correct minute and second
  always_comb begin
    if (s9_sraw_q >= 7'(MIN_SECS)) begin
      s10_min_d = s9_mest_q + 6'd1;
      s10_sec_d = 6'(s9_sraw_q - 7'(MIN_SECS));
    end else begin
      s10_min_d = s9_mest_q;
      s10_sec_d = s9_sraw_q[5:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_secs_q   <= s1_secs_d;
      s2_q1_q     <= s1_secs_q[31:7];
      s2_lo_q     <= s1_secs_q[6:0];
      s2_dest_q   <= day_prod[46:32];
      s3_dest_q   <= s2_dest_q;
      s3_draw_q   <= s3_draw_full[10:0];
      s3_lo_q     <= s2_lo_q;
      s4_days_q   <= s4_days_d;
      s4_tod_q    <= {s4_r_d, s3_lo_q};
      s5_days_q   <= s4_days_q;
      s5_tod_q    <= s4_tod_q;
      s5_cest_q   <= cyc_prod[30:26];
      s5_hest_q   <= hr_prod[33:29];
      s6_cest_q   <= s5_cest_q;
      s6_craw_q   <= craw_full[11:0];
      s6_hest_q   <= s5_hest_q;
      s6_hraw_q   <= hraw_full[12:0];
      s7_cyc_q    <= s7_cyc_d;
      s7_doy_q    <= s7_doy_d;
      s7_hour_q   <= s7_hour_d;
      s7_rem_q    <= s7_rem_d;
      s8_year_q   <= s8_year_d;
      s8_doy_q    <= s8_doy_full[8:0];
      s8_leap_q   <= s8_leap_d;
      s8_hour_q   <= s7_hour_q;
      s8_rem_q    <= s7_rem_q;
      s8_mest_q   <= min_prod[23:18];
      s9_year_q   <= s8_year_q;
      s9_month_q  <= m_idx + 4'd1;
      s9_day_q    <= day_full[4:0];
      s9_hour_q   <= s8_hour_q;
      s9_mest_q   <= s8_mest_q;
      s9_sraw_q   <= sraw_full[6:0];
      s10_year_q  <= s9_year_q;
      s10_month_q <= s9_month_q;
      s10_day_q   <= s9_day_q;
      s10_hour_q  <= s9_hour_q;
      s10_min_q   <= s10_min_d;
      s10_sec_q   <= s10_sec_d;
    end
  end

  // outputs
  assign valid_o  = vld_q[Stages-1];
  assign year_o   = s10_year_q;
  assign month_o  = s10_month_q;
  assign day_o    = s10_day_q;
  assign hour_o   = s10_hour_q;
  assign minute_o = s10_min_q;
  assign second_o = s10_sec_q;

endmodule

/* dv/epoch_seconds_to_calendar_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb: checks the unix seconds to local date converter
// Feeds directed corner words, such as day, month, year and leap day edges and
// the largest input, followed by random words that lean on calendar
// boundaries. Every word is predicted in the bench and compared field by
// field with the result stream. Random gaps and stalls are applied on both
// sides, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;
  import es2cal_pkg::*;

  // calendar constants for the predictor
  localparam int     ZONE_S       = 28800;
  localparam int     DAY_S        = 86400;
  localparam int     YEAR_D       = 365;
  localparam int     CYCLE_D      = 1461;
  localparam int     EPOCH_YEAR   = 1970;
  localparam int     LAST_CYCLE   = 17;
  localparam longint EPOCH_MAX    = 64'd2147483647;
  localparam int     MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // run control
  localparam int RANDOM_WORDS = 1700;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int CORNER_COUNT = 24;

  // local midnights, month and year ends, leap days, bit patterns, largest input
  localparam logic [EpochW-1:0] CORNER_WORDS [CORNER_COUNT] = '{
    31'd0,         31'd1,          31'd59,         31'd3599,
    31'd57599,     31'd57600,      31'd31507199,   31'd31507200,
    31'd68111999,  31'd68112000,   31'd68198399,   31'd68198400,
    31'd94579200,  31'd94665599,   31'd94665600,   31'd126201599,
    31'd126201600, 31'd951753600,  31'd1234567890, 31'h55555555,
    31'h2AAAAAAA,  31'd2147454847, 31'd2147483646, 31'd2147483647
  };

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } cal_t;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               valid_i         = 1'b0;
  logic               stall_o;
  logic [EpochW-1:0]  epoch_seconds_i = '0;
  logic               valid_o;
  logic               stall_i         = 1'b0;
  logic [YearW-1:0]   year_o;
  logic [MonthW-1:0]  month_o;
  logic [DayW-1:0]    day_o;
  logic [HourW-1:0]   hour_o;
  logic [MinuteW-1:0] minute_o;
  logic [SecondW-1:0] second_o;

  logic [EpochW-1:0] epoch_queue [$];
  cal_t              cal_expected [$];

  logic        hold_req        = 1'b0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  int unsigned cycle_count     = 0;
  int unsigned words_accepted  = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned dates_checked   = 0;
  int unsigned error_count     = 0;
  int unsigned year_lo         = 4095;
  int unsigned year_hi         = 0;

  epoch_seconds_to_calendar u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .epoch_seconds_i (epoch_seconds_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

  // clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // local date and time of a utc seconds count
  function automatic cal_t to_calendar(logic [EpochW-1:0] utc_s);
    int unsigned zoned_s, days, tod, yr, doy, mon, len, k;
    bit          leap;
    cal_t        res;
    zoned_s = int'(utc_s) + ZONE_S;
    days    = zoned_s / DAY_S;
    tod     = zoned_s % DAY_S;
    yr      = EPOCH_YEAR + (days / CYCLE_D) * 4;
    doy     = days % CYCLE_D;
    leap    = 1'b0;
    // position inside the four-year cycle, third year is the leap year
    if (doy >= 3 * YEAR_D + 1) begin
      doy -= 3 * YEAR_D + 1;
      yr  += 3;
    end else if (doy >= 2 * YEAR_D) begin
      doy  -= 2 * YEAR_D;
      yr   += 2;
      leap  = 1'b1;
    end else begin
      yr  += doy / YEAR_D;
      doy  = doy % YEAR_D;
    end
    // walk the month lengths
    mon = 1;
    for (k = 0; k < 12; k++) begin
      len = MONTH_LEN[k] + ((k == 1 && leap) ? 1 : 0);
      if (doy < len) break;
      doy -= len;
      mon++;
    end
    if (mon > 12) mon = 12;
    res.year   = YearW'(yr);
    res.month  = MonthW'(mon);
    res.day    = DayW'(doy + 1);
    res.hour   = HourW'(tod / 3600);
    res.minute = MinuteW'((tod % 3600) / 60);
    res.second = SecondW'(tod % 60);
    return res;
  endfunction

  // idle run length: mostly short, a few long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // random word, biased toward local midnights and month starts
  function automatic logic [EpochW-1:0] random_epoch();
    longint      v;
    int unsigned sel, day, yi, m, k;
    sel = $urandom_range(9);
    case (sel)
      4, 5: begin
        day = $urandom_range(LAST_CYCLE * CYCLE_D + 2 * YEAR_D);
        v   = longint'(day) * DAY_S - ZONE_S + (int'($urandom_range(4)) - 2);
      end
      6, 7: begin
        day = $urandom_range(LAST_CYCLE) * CYCLE_D;
        yi  = $urandom_range(3);
        for (k = 0; k < yi; k++) day += (k == 2) ? YEAR_D + 1 : YEAR_D;
        m = $urandom_range(11);
        for (k = 0; k < m; k++) day += MONTH_LEN[k] + ((k == 1 && yi == 2) ? 1 : 0);
        v = longint'(day) * DAY_S - ZONE_S;
        if (sel == 6) v += int'($urandom_range(6)) - 3;
        else v += $urandom_range(DAY_S - 1);
      end
      8:       v = EPOCH_MAX - $urandom_range(400000);
      9:       v = $urandom_range(400000);
      default: v = $urandom_range(int'(EPOCH_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > EPOCH_MAX) v = EPOCH_MAX;
    return v[EpochW-1:0];
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // input driver: one word per handshake, random gaps, every third stretch gap-free
  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    logic [EpochW-1:0] nxt;
    if (!rst_ni) begin
      valid_i         <= 1'b0;
      epoch_seconds_i <= '0;
      gap_left        <= 0;
    end else if (valid_i && stall_o) begin
      in_stall_cycles <= in_stall_cycles + 1;
    end else begin
      if (valid_i) words_accepted <= words_accepted + 1;
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        valid_i  <= 1'b0;
      end else if (epoch_queue.size() != 0) begin
        nxt = epoch_queue.pop_front();
        cal_expected.push_back(to_calendar(nxt));
        epoch_seconds_i <= nxt;
        valid_i         <= 1'b1;
        gap_left        <= ((words_accepted / 200) % 3 == 1) ? 0 : idle_length();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // receiver stall: random runs, quiet stretches, plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    int unsigned run_len;
    if (!rst_ni) begin
      stall_i    <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      stall_i    <= 1'b1;
    end else begin
      run_len    = ((cycle_count / 700) % 3 == 2) ? 0 : idle_length();
      stall_left <= (run_len == 0) ? 0 : run_len - 1;
      stall_i    <= hold_req || (run_len != 0);
    end
  end

  // long hold-off on the output while the sender keeps offering words
  initial begin : output_hold_off
    wait (words_accepted >= 500);
    @(posedge clk_i);
    hold_req <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_req <= 1'b0;
  end

  // result monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : date_monitor
    cal_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (cal_expected.size() == 0) begin
        $error("result word with no prediction pending: %0d-%0d-%0d %0d:%0d:%0d",
               year_o, month_o, day_o, hour_o, minute_o, second_o);
        error_count++;
      end else begin
        want = cal_expected.pop_front();
        check_field("year", want.year, year_o);
        check_field("month", want.month, month_o);
        check_field("day", want.day, day_o);
        check_field("hour", want.hour, hour_o);
        check_field("minute", want.minute, minute_o);
        check_field("second", want.second, second_o);
        dates_checked++;
        if (year_o < year_lo) year_lo = year_o;
        if (year_o > year_hi) year_hi = year_o;
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int i;
    for (i = 0; i < CORNER_COUNT; i++) epoch_queue.push_back(CORNER_WORDS[i]);
    for (i = 0; i < RANDOM_WORDS; i++) epoch_queue.push_back(random_epoch());
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (epoch_queue.size() != 0 || valid_i) @(posedge clk_i);
    while (cal_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d words converted and checked (%0d corner words), years %0d to %0d",
             dates_checked, CORNER_COUNT, year_lo, year_hi);
    $display("input held off for %0d cycles, including a %0d-cycle output hold-off",
             in_stall_cycles, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/es2cal_pkg.sv
rtl/epoch_seconds_to_calendar.sv
dv/epoch_seconds_to_calendar_tb.sv
